@@ hdl/frdl_pkg.sv @@
// ----------------------------------------------------------------------------
// frdl_pkg
// Shared constants, codes and types of the FAT32 root-directory lookup and
// sector walk core.
// ----------------------------------------------------------------------------
package frdl_pkg;

  localparam int DIR_SECTORS  = 16;
  localparam int SECTOR_BYTES = 512;

  localparam int EPS         = SECTOR_BYTES / 32;   // entries per sector
  localparam int EPS_SHIFT   = $clog2(EPS);
  localparam int DIR_ENTRIES = DIR_SECTORS * EPS;
  localparam int EI_W        = $clog2(DIR_ENTRIES + 1);

  localparam logic [31:0] SECTOR_BYTES_W = 32'(SECTOR_BYTES);
  localparam logic [31:0] CHAIN_END      = 32'h0FFF_FFF8;
  localparam logic [7:0]  NAME_END       = 8'h00;
  localparam logic [7:0]  NAME_DELETED   = 8'hE5;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_DATA_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_SEC = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_CLUST  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_MAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NAME_EXT    = 3'd4;

  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_ENTRY = 2'd1;
  localparam logic [1:0] MODE_DATA  = 2'd2;

  localparam logic [2:0] ST_SEARCHING = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_DATA      = 3'd3;
  localparam logic [2:0] ST_IGNORED   = 3'd4;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SEARCH = 2'd1;
  localparam logic [1:0] PH_WALK   = 2'd2;

  typedef struct packed {
    logic [31:0] data_start_sector;
    logic [7:0]  cluster_sectors;
    logic [27:0] dir_root_clus;
    logic [63:0] wanted_name_main;
    logic [23:0] wanted_name_ext;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] entry_name_main;
    logic [23:0] entry_name_ext;
    logic [15:0] cluster_high;
    logic [15:0] cluster_low;
    logic [31:0] entry_size;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] sector;
    logic [9:0]  byte_count;
    logic [31:0] start_clus;
    logic [31:0] size_bytes;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0]      phase;
    logic [EI_W-1:0] entry_index;
    logic [31:0]     cur_clus;
    logic [7:0]      sector_in_cluster;
    logic [31:0]     bytes_left;
    logic [31:0]     found_size;
  } walk_state_t;

endpackage

@@ hdl/fat_root_dir_lookup_sector_walk_core.sv @@
// ----------------------------------------------------------------------------
// fat_root_dir_lookup_sector_walk_core
// FAT32 root-directory name lookup and contiguous-file data sector walker.
// ----------------------------------------------------------------------------
// Takes one item per cycle while in_stall is low and returns one result per
// item. An accepted item waits in the input register while combinational
// logic (an 8.3 name compare and a single cluster-times-sectors multiply
// with a three-term add) forms its result; the result is then loaded into
// the result register, which drives out_valid. The result register does not
// block the next item while it waits to be taken; a stall reaches the input
// only when both stages hold. Mode 0 starts a search, mode 1 feeds one
// directory entry, mode 2 asks for the next data sector. Configuration must
// be written only while no item is in flight.
module fat_root_dir_lookup_sector_walk_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frdl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [63:0]                    in_entry_name_main,
  input  logic [23:0]                    in_entry_name_ext,
  input  logic [15:0]                    in_cluster_high,
  input  logic [15:0]                    in_cluster_low,
  input  logic [31:0]                    in_entry_size,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_status,
  output logic [31:0]                    out_sector,
  output logic [9:0]                     out_byte_count,
  output logic [31:0]                    out_start_clus,
  output logic [31:0]                    out_size_bytes,
  output logic                           out_last
);

  frdl_pkg::cfg_t        cfg_r;
  frdl_pkg::walk_state_t st_r;
  frdl_pkg::walk_state_t st_nxt;
  frdl_pkg::item_t       s1_item_r;
  logic                  s1_valid_r;
  frdl_pkg::result_t     res_nxt;
  frdl_pkg::result_t     out_res_r;
  logic                  out_valid_r;
  logic                  out_free;
  logic                  s1_fire;
  logic                  in_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_start_sector <= 32'd0;
      cfg_r.cluster_sectors   <= 8'd1;
      cfg_r.dir_root_clus     <= 28'd2;
      cfg_r.wanted_name_main  <= 64'd0;
      cfg_r.wanted_name_ext   <= 24'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        frdl_pkg::CFG_DATA_START:  cfg_r.data_start_sector <= cfg_wdata[31:0];
        frdl_pkg::CFG_CLUSTER_SEC: cfg_r.cluster_sectors   <= cfg_wdata[7:0];
        frdl_pkg::CFG_ROOT_CLUST:  cfg_r.dir_root_clus     <= cfg_wdata[27:0];
        frdl_pkg::CFG_NAME_MAIN:   cfg_r.wanted_name_main  <= cfg_wdata;
        frdl_pkg::CFG_NAME_EXT:    cfg_r.wanted_name_ext   <= cfg_wdata[23:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode            <= in_mode;
      s1_item_r.entry_name_main <= in_entry_name_main;
      s1_item_r.entry_name_ext  <= in_entry_name_ext;
      s1_item_r.cluster_high    <= in_cluster_high;
      s1_item_r.cluster_low     <= in_cluster_low;
      s1_item_r.entry_size      <= in_entry_size;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  frdl_step u_step (
    .cfg    (cfg_r),
    .item   (s1_item_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_sector     = out_res_r.sector;
  assign out_byte_count = out_res_r.byte_count;
  assign out_start_clus = out_res_r.start_clus;
  assign out_size_bytes = out_res_r.size_bytes;
  assign out_last       = out_res_r.last;

endmodule

@@ hdl/frdl_step.sv @@
// ----------------------------------------------------------------------------
// frdl_step
// Next-state and result logic for one item: directory entry check, name
// compare, and cluster-to-sector address calculation on one shared multiply.
// ----------------------------------------------------------------------------
module frdl_step (
  input  frdl_pkg::cfg_t        cfg,
  input  frdl_pkg::item_t       item,
  input  frdl_pkg::walk_state_t st,
  output frdl_pkg::walk_state_t st_nxt,
  output frdl_pkg::result_t     res
);

  logic                      is_data;
  logic [7:0]                spc;
  logic [frdl_pkg::EI_W-1:0] ei_inc;
  logic [frdl_pkg::EI_W-1:0] ei_sel;
  logic [31:0]               mul_cl;
  logic [31:0]               cl_m2;
  logic [39:0]               prod;
  logic [31:0]               offset;
  logic [31:0]               sector_calc;
  logic [31:0]               fc;
  logic                      name_hit;
  logic [31:0]               count;
  logic [31:0]               bl_nxt;
  logic [8:0]                sic_inc;
  logic [31:0]               cl_nxt;

  assign is_data = (item.mode == frdl_pkg::MODE_DATA);
  assign spc     = (cfg.cluster_sectors == 8'd0) ? 8'd1 : cfg.cluster_sectors;
  assign ei_inc  = st.entry_index + 1'b1;
  assign ei_sel  = (item.mode == frdl_pkg::MODE_START) ? '0 : ei_inc;

  // shared: base = data_start + (cluster - 2) * spc, plus an offset
  assign mul_cl = is_data ? st.cur_clus : {4'd0, cfg.dir_root_clus};
  assign cl_m2  = mul_cl - 32'd2;
  assign prod   = cl_m2 * spc;
  assign offset = is_data ? {24'd0, st.sector_in_cluster}
                          : ({{(32-frdl_pkg::EI_W){1'b0}}, ei_sel} >> frdl_pkg::EPS_SHIFT);
  assign sector_calc = cfg.data_start_sector + prod[31:0] + offset;

  assign fc       = {item.cluster_high, item.cluster_low};
  assign name_hit = (item.entry_name_main[7:0] != frdl_pkg::NAME_DELETED) &&
                    (item.entry_name_main == cfg.wanted_name_main) &&
                    (item.entry_name_ext == cfg.wanted_name_ext);

  assign count   = (st.bytes_left > frdl_pkg::SECTOR_BYTES_W) ? frdl_pkg::SECTOR_BYTES_W
                                                              : st.bytes_left;
  assign bl_nxt  = st.bytes_left - count;
  assign sic_inc = {1'b0, st.sector_in_cluster} + 9'd1;
  assign cl_nxt  = (sic_inc >= {1'b0, spc}) ? st.cur_clus + 32'd1
                                            : st.cur_clus;

  always_comb begin
    st_nxt = st;
    res    = '0;
    res.status = frdl_pkg::ST_IGNORED;
    case (item.mode)
      frdl_pkg::MODE_START: begin
        st_nxt.phase       = frdl_pkg::PH_SEARCH;
        st_nxt.entry_index = '0;
        res.status         = frdl_pkg::ST_SEARCHING;
        res.sector         = sector_calc;
      end
      frdl_pkg::MODE_ENTRY: begin
        if (st.phase == frdl_pkg::PH_SEARCH) begin
          if (item.entry_name_main[7:0] == frdl_pkg::NAME_END) begin
            res.status   = frdl_pkg::ST_NOT_FOUND;
            st_nxt.phase = frdl_pkg::PH_IDLE;
          end else if (name_hit) begin
            res.status               = frdl_pkg::ST_FOUND;
            res.start_clus           = fc;
            res.size_bytes           = item.entry_size;
            st_nxt.found_size        = item.entry_size;
            st_nxt.cur_clus          = fc;
            st_nxt.sector_in_cluster = 8'd0;
            st_nxt.bytes_left        = item.entry_size;
            st_nxt.phase = (item.entry_size != 32'd0 && fc < frdl_pkg::CHAIN_END) ?
                           frdl_pkg::PH_WALK : frdl_pkg::PH_IDLE;
          end else begin
            st_nxt.entry_index = ei_inc;
            if (ei_inc >= frdl_pkg::EI_W'(frdl_pkg::DIR_ENTRIES)) begin
              res.status   = frdl_pkg::ST_NOT_FOUND;
              st_nxt.phase = frdl_pkg::PH_IDLE;
            end else begin
              res.status = frdl_pkg::ST_SEARCHING;
              res.sector = sector_calc;
            end
          end
        end
      end
      frdl_pkg::MODE_DATA: begin
        if (st.phase == frdl_pkg::PH_WALK) begin
          res.status               = frdl_pkg::ST_DATA;
          res.sector               = sector_calc;
          res.byte_count           = count[9:0];
          res.size_bytes           = st.found_size;
          st_nxt.bytes_left        = bl_nxt;
          st_nxt.sector_in_cluster = (sic_inc >= {1'b0, spc}) ? 8'd0 : sic_inc[7:0];
          st_nxt.cur_clus          = cl_nxt;
          if (bl_nxt == 32'd0 || cl_nxt >= frdl_pkg::CHAIN_END) begin
            res.last     = 1'b1;
            st_nxt.phase = frdl_pkg::PH_IDLE;
          end
        end
      end
      default: begin
        res.status = frdl_pkg::ST_IGNORED;
      end
    endcase
  end

endmodule

@@ hdl/frdl_checker.sv @@
// ----------------------------------------------------------------------------
// frdl_checker
// Port-level checks of the lookup and sector walk core, bound to the top.
// ----------------------------------------------------------------------------
module frdl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [31:0] out_sector,
  input logic [9:0]  out_byte_count,
  input logic [31:0] out_start_clus,
  input logic [31:0] out_size_bytes,
  input logic        out_last
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_non_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != frdl_pkg::ST_DATA |-> out_byte_count == 10'd0 && !out_last)
    else $error("byte count or last outside a data result");

  a_data_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == frdl_pkg::ST_DATA |->
      out_byte_count <= 10'd512 && out_start_clus == 32'd0)
    else $error("bad data result fields");

  a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == frdl_pkg::ST_IGNORED ||
                  out_status == frdl_pkg::ST_NOT_FOUND) |->
      out_sector == 32'd0 && out_size_bytes == 32'd0 && out_start_clus == 32'd0)
    else $error("fields not cleared on ignored or not-found result");

endmodule

bind fat_root_dir_lookup_sector_walk_core frdl_checker u_frdl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_status     (out_status),
  .out_sector     (out_sector),
  .out_byte_count (out_byte_count),
  .out_start_clus (out_start_clus),
  .out_size_bytes (out_size_bytes),
  .out_last       (out_last)
);

@@ verif/fat_root_dir_lookup_sector_walk_core_check.sv @@
// ----------------------------------------------------------------------------
// FAT32 root-directory lookup core: result checker
// Watches the configuration port and both item channels of the core. Keeps
// its own copy of the registers and of the search and walk state, predicts
// the result of every accepted item and compares each accepted result, field
// by field, with the oldest prediction. Mismatches are counted for the top.
// ----------------------------------------------------------------------------
module fat_root_dir_lookup_sector_walk_core_check (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [frdl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frdl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [1:0]                     in_mode,
  input  logic [63:0]                    in_entry_name_main,
  input  logic [23:0]                    in_entry_name_ext,
  input  logic [15:0]                    in_cluster_high,
  input  logic [15:0]                    in_cluster_low,
  input  logic [31:0]                    in_entry_size,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [2:0]                     out_status,
  input  logic [31:0]                    out_sector,
  input  logic [9:0]                     out_byte_count,
  input  logic [31:0]                    out_start_clus,
  input  logic [31:0]                    out_size_bytes,
  input  logic                           out_last,
  output int                             fail_count,
  output int                             pending,
  output int                             checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [31:0] data_start_q;
  logic [7:0]  clus_sectors_q;
  logic [27:0] dir_root_q;
  logic [63:0] name_main_q;
  logic [23:0] name_ext_q;

  logic [1:0]  walk_phase;
  int          dir_pos;
  logic [31:0] cur_cluster;
  logic [31:0] sec_in_clus;
  logic [31:0] remaining;
  logic [31:0] matched_size;

  frdl_pkg::result_t awaited_answers[$];

  function automatic logic [31:0] clus_span();
    return (clus_sectors_q == 8'd0) ? 32'd1 : {24'd0, clus_sectors_q};
  endfunction

  function automatic logic [31:0] cluster_first_sector(input logic [31:0] clus);
    return data_start_q + (clus - 32'd2) * clus_span();
  endfunction

  function automatic logic [31:0] dir_sector_addr();
    return cluster_first_sector({4'd0, dir_root_q}) + 32'(dir_pos / frdl_pkg::EPS);
  endfunction

  function automatic frdl_pkg::result_t lookup_step(input frdl_pkg::item_t it);
    frdl_pkg::result_t r;
    logic [31:0]       clus;
    logic [31:0]       take;
    r = '0;
    r.status = frdl_pkg::ST_IGNORED;
    if (it.mode == frdl_pkg::MODE_START) begin
      walk_phase = frdl_pkg::PH_SEARCH;
      dir_pos = 0;
      r.status = frdl_pkg::ST_SEARCHING;
      r.sector = dir_sector_addr();
    end else if (it.mode == frdl_pkg::MODE_ENTRY && walk_phase == frdl_pkg::PH_SEARCH) begin
      if (it.entry_name_main[7:0] == frdl_pkg::NAME_END) begin
        r.status = frdl_pkg::ST_NOT_FOUND;
        walk_phase = frdl_pkg::PH_IDLE;
      end else if (it.entry_name_main[7:0] != frdl_pkg::NAME_DELETED &&
                   it.entry_name_main == name_main_q &&
                   it.entry_name_ext == name_ext_q) begin
        clus = {it.cluster_high, it.cluster_low};
        r.status = frdl_pkg::ST_FOUND;
        r.start_clus = clus;
        r.size_bytes = it.entry_size;
        matched_size = it.entry_size;
        cur_cluster = clus;
        sec_in_clus = 0;
        remaining = it.entry_size;
        walk_phase = (it.entry_size != 0 && clus < frdl_pkg::CHAIN_END) ?
                     frdl_pkg::PH_WALK : frdl_pkg::PH_IDLE;
      end else begin
        dir_pos++;
        if (dir_pos >= frdl_pkg::DIR_ENTRIES) begin
          r.status = frdl_pkg::ST_NOT_FOUND;
          walk_phase = frdl_pkg::PH_IDLE;
        end else begin
          r.status = frdl_pkg::ST_SEARCHING;
          r.sector = dir_sector_addr();
        end
      end
    end else if (it.mode == frdl_pkg::MODE_DATA && walk_phase == frdl_pkg::PH_WALK) begin
      r.status = frdl_pkg::ST_DATA;
      r.sector = cluster_first_sector(cur_cluster) + sec_in_clus;
      take = (remaining > frdl_pkg::SECTOR_BYTES_W) ? frdl_pkg::SECTOR_BYTES_W : remaining;
      remaining = remaining - take;
      r.byte_count = take[9:0];
      r.size_bytes = matched_size;
      sec_in_clus = sec_in_clus + 32'd1;
      if (sec_in_clus >= clus_span()) begin
        sec_in_clus = 0;
        cur_cluster = cur_cluster + 32'd1;
      end
      if (remaining == 0 || cur_cluster >= frdl_pkg::CHAIN_END) begin
        r.last = 1'b1;
        walk_phase = frdl_pkg::PH_IDLE;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    frdl_pkg::item_t   it;
    frdl_pkg::result_t want;
    if (!rst_n) begin
      data_start_q = '0;
      clus_sectors_q = 8'd1;
      dir_root_q = 28'd2;
      name_main_q = '0;
      name_ext_q = '0;
      walk_phase = frdl_pkg::PH_IDLE;
      dir_pos = 0;
      cur_cluster = '0;
      sec_in_clus = '0;
      remaining = '0;
      matched_size = '0;
      awaited_answers.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          frdl_pkg::CFG_DATA_START:  data_start_q = cfg_wdata[31:0];
          frdl_pkg::CFG_CLUSTER_SEC: clus_sectors_q = cfg_wdata[7:0];
          frdl_pkg::CFG_ROOT_CLUST:  dir_root_q = cfg_wdata[27:0];
          frdl_pkg::CFG_NAME_MAIN:   name_main_q = cfg_wdata;
          frdl_pkg::CFG_NAME_EXT:    name_ext_q = cfg_wdata[23:0];
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("unexpected result, status", out_status, 0);
        end else begin
          want = awaited_answers.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", out_status, want.status);
          if (out_sector !== want.sector)
            report_mismatch("sector", out_sector, want.sector);
          if (out_byte_count !== want.byte_count)
            report_mismatch("byte_count", out_byte_count, want.byte_count);
          if (out_start_clus !== want.start_clus)
            report_mismatch("start_clus", out_start_clus, want.start_clus);
          if (out_size_bytes !== want.size_bytes)
            report_mismatch("size_bytes", out_size_bytes, want.size_bytes);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
          checked++;
        end
      end
      if (in_valid && in_stall === 1'b0) begin
        it.mode = in_mode;
        it.entry_name_main = in_entry_name_main;
        it.entry_name_ext = in_entry_name_ext;
        it.cluster_high = in_cluster_high;
        it.cluster_low = in_cluster_low;
        it.entry_size = in_entry_size;
        awaited_answers.push_back(lookup_step(it));
      end
    end
    pending = awaited_answers.size();
  end

endmodule

@@ verif/fat_root_dir_lookup_sector_walk_core_test.sv @@
// ----------------------------------------------------------------------------
// FAT32 root-directory lookup core: testbench top
// Drives the core with a directed opening (ignored items, the unused mode,
// deleted and end-of-directory entries, empty walks, end of chain, restart
// in a walk, zero cluster size, address wrap), then random file lookups
// with random content, noise items and a full directory scan, under random
// sender gaps and receiver stalls. The checker beside the core predicts and
// compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module fat_root_dir_lookup_sector_walk_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED  = 2'd3;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         TARGET_ITEMS = 420;
  localparam logic [63:0] README_NAME = 64'h2020_454D_4441_4552;
  localparam logic [23:0] TXT_EXT     = 24'h54_58_54;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [frdl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [frdl_pkg::CFG_W-1:0]     cfg_wdata = '0;
  logic                           in_valid = 1'b0;
  logic                           in_stall;
  logic [1:0]                     in_mode = '0;
  logic [63:0]                    in_entry_name_main = '0;
  logic [23:0]                    in_entry_name_ext = '0;
  logic [15:0]                    in_cluster_high = '0;
  logic [15:0]                    in_cluster_low = '0;
  logic [31:0]                    in_entry_size = '0;
  logic                           out_valid;
  logic                           out_stall = 1'b0;
  logic [2:0]                     out_status;
  logic [31:0]                    out_sector;
  logic [9:0]                     out_byte_count;
  logic [31:0]                    out_start_clus;
  logic [31:0]                    out_size_bytes;
  logic                           out_last;

  int fail_count;
  int pending;
  int checked;

  int cycle_count = 0;
  int stall_style = 0;
  int stall_run = 0;
  int burst_left = 0;
  int counted_items = 0;
  int n_start = 0;
  int n_entry = 0;
  int n_data = 0;
  int n_other = 0;
  int n_cfg = 0;

  logic [63:0] want_main = '0;
  logic [23:0] want_ext = '0;

  fat_root_dir_lookup_sector_walk_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_entry_name_main(in_entry_name_main),
    .in_entry_name_ext (in_entry_name_ext),
    .in_cluster_high   (in_cluster_high),
    .in_cluster_low    (in_cluster_low),
    .in_entry_size     (in_entry_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_sector        (out_sector),
    .out_byte_count    (out_byte_count),
    .out_start_clus    (out_start_clus),
    .out_size_bytes    (out_size_bytes),
    .out_last          (out_last)
  );

  fat_root_dir_lookup_sector_walk_core_check i_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_mode           (in_mode),
    .in_entry_name_main(in_entry_name_main),
    .in_entry_name_ext (in_entry_name_ext),
    .in_cluster_high   (in_cluster_high),
    .in_cluster_low    (in_cluster_low),
    .in_entry_size     (in_entry_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_sector        (out_sector),
    .out_byte_count    (out_byte_count),
    .out_start_clus    (out_start_clus),
    .out_size_bytes    (out_size_bytes),
    .out_last          (out_last),
    .fail_count        (fail_count),
    .pending           (pending),
    .checked           (checked)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_run == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_run <= $urandom_range(20, 150);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cycle_count[1];
    endcase
  end

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_item(input logic [1:0] mode, input logic [63:0] nm,
                           input logic [23:0] ext, input logic [31:0] cl,
                           input logic [31:0] size, input bit counted);
    if (burst_left == 0) begin
      repeat (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    in_mode = mode;
    in_entry_name_main = nm;
    in_entry_name_ext = ext;
    in_cluster_high = cl[31:16];
    in_cluster_low = cl[15:0];
    in_entry_size = size;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
    if (counted) counted_items++;
    case (mode)
      frdl_pkg::MODE_START: n_start++;
      frdl_pkg::MODE_ENTRY: n_entry++;
      frdl_pkg::MODE_DATA:  n_data++;
      default:              n_other++;
    endcase
  endtask

  task automatic send_ctl(input logic [1:0] mode);
    send_item(mode, rnd64(), 24'($urandom), $urandom, $urandom, 1'b1);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [frdl_pkg::CFG_IDX_W-1:0] idx,
                           input logic [frdl_pkg::CFG_W-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == frdl_pkg::CFG_NAME_MAIN) want_main = val;
    if (idx == frdl_pkg::CFG_NAME_EXT) want_ext = val[23:0];
    n_cfg++;
  endtask

  task automatic miss_entry(output logic [63:0] nm, output logic [23:0] ext);
    nm = rnd64();
    ext = 24'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        nm = want_main;
        ext = want_ext;
        nm[$urandom_range(0, 63)] ^= 1'b1;
      end
      1: begin
        nm = want_main;
        ext = want_ext;
        ext[$urandom_range(0, 23)] ^= 1'b1;
      end
      2: begin
        nm = want_main;
        ext = want_ext;
        nm[7:0] = frdl_pkg::NAME_DELETED;
      end
      default: ;
    endcase
    if (nm[7:0] == frdl_pkg::NAME_END) nm[7:0] = 8'h20;
    if (nm[7:0] != frdl_pkg::NAME_DELETED && nm == want_main && ext == want_ext)
      ext[0] = ~ext[0];
  endtask

  task automatic reconfigure();
    logic [63:0] nm;
    wait_idle();
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: write_reg(frdl_pkg::CFG_DATA_START, 64'd0);
        1: write_reg(frdl_pkg::CFG_DATA_START, 64'hFFFF_FFFF);
        default: write_reg(frdl_pkg::CFG_DATA_START, 64'($urandom));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 5))
        0: write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd0);
        1: write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd1);
        2: write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd128);
        3: write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd255);
        default: write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'($urandom_range(1, 16)));
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0: write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'd2);
        1: write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'h0FFF_FFFF);
        2: write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'($urandom_range(0, 1)));
        default: write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'($urandom) & 64'h0FFF_FFFF);
      endcase
    end
    if ($urandom_range(0, 1) == 0) begin
      nm = rnd64();
      if ($urandom_range(0, 3) != 0) nm[7:0] = 8'($urandom_range(8'h41, 8'h5A));
      write_reg(frdl_pkg::CFG_NAME_MAIN, nm);
    end
    if ($urandom_range(0, 1) == 0)
      write_reg(frdl_pkg::CFG_NAME_EXT, 64'($urandom) & 64'hFF_FFFF);
  endtask

  // start, some non-matching entries, then either the end mark or the match
  // followed by its data sector requests
  task automatic lookup_file();
    logic [63:0] nm;
    logic [23:0] ext;
    logic [31:0] cl;
    logic [31:0] size;
    int          reqs;
    send_ctl(frdl_pkg::MODE_START);
    repeat (($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 6)) begin
      miss_entry(nm, ext);
      send_item(frdl_pkg::MODE_ENTRY, nm, ext, $urandom, $urandom, 1'b1);
    end
    if ($urandom_range(0, 7) == 0) begin
      nm = rnd64();
      nm[7:0] = frdl_pkg::NAME_END;
      send_item(frdl_pkg::MODE_ENTRY, nm, 24'($urandom), $urandom, $urandom, 1'b1);
    end else begin
      case ($urandom_range(0, 7))
        0: cl = frdl_pkg::CHAIN_END - 32'd8 + 32'($urandom_range(0, 15));
        1: cl = $urandom;
        2: cl = 32'($urandom_range(0, 1));
        default: cl = 32'($urandom_range(2, 5000));
      endcase
      case ($urandom_range(0, 9))
        0: size = 32'd0;
        1: size = $urandom;
        2: size = 32'(512 * $urandom_range(1, 6));
        default: size = 32'($urandom_range(1, 4000));
      endcase
      send_item(frdl_pkg::MODE_ENTRY, want_main, want_ext, cl, size, 1'b1);
      reqs = (size > 32'd5120) ? $urandom_range(3, 10) : int'((size + 32'd511) / 32'd512);
      if ($urandom_range(0, 9) == 0) reqs = $urandom_range(0, reqs);
      repeat (reqs) send_ctl(frdl_pkg::MODE_DATA);
      if ($urandom_range(0, 4) == 0)
        send_item(frdl_pkg::MODE_DATA, rnd64(), 24'($urandom), $urandom, $urandom, 1'b0);
    end
  endtask

  initial begin
    logic [63:0] nm;
    logic [23:0] ext;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // registers at reset values
    send_ctl(frdl_pkg::MODE_DATA);
    send_ctl(frdl_pkg::MODE_ENTRY);
    send_ctl(MODE_UNUSED);
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, 64'd0, 24'd0, 32'd0, 32'd0, 1'b1);

    // address wrap, zero cluster size read as one
    wait_idle();
    write_reg(frdl_pkg::CFG_DATA_START, 64'hFFFF_FFFF);
    write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd0);
    write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'h0FFF_FFFF);
    write_reg(frdl_pkg::CFG_NAME_MAIN, README_NAME);
    write_reg(frdl_pkg::CFG_NAME_EXT, 64'(TXT_EXT));
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, {README_NAME[63:8], frdl_pkg::NAME_DELETED}, TXT_EXT,
              32'd9, 32'd9, 1'b1);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT ^ 24'h800000, 32'd9, 32'd9, 1'b1);
    send_item(MODE_UNUSED, '1, '1, '1, '1, 1'b1);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, frdl_pkg::CHAIN_END - 32'd1,
              32'd5000, 1'b1);
    send_ctl(frdl_pkg::MODE_DATA);
    send_ctl(frdl_pkg::MODE_DATA);
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'h0001_2345, 32'd0, 1'b1);
    send_ctl(frdl_pkg::MODE_DATA);
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'd3, 32'd1500, 1'b1);
    send_ctl(frdl_pkg::MODE_DATA);
    send_ctl(frdl_pkg::MODE_START);
    send_ctl(frdl_pkg::MODE_DATA);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'd2, 32'd512, 1'b1);
    send_ctl(frdl_pkg::MODE_DATA);

    // 128-sector cluster, entry during a walk
    wait_idle();
    write_reg(frdl_pkg::CFG_DATA_START, 64'd0);
    write_reg(frdl_pkg::CFG_CLUSTER_SEC, 64'd128);
    write_reg(frdl_pkg::CFG_ROOT_CLUST, 64'd2);
    send_ctl(frdl_pkg::MODE_START);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'd2, 32'd1025, 1'b1);
    send_item(frdl_pkg::MODE_ENTRY, README_NAME, TXT_EXT, 32'd7, 32'd7, 1'b1);
    repeat (3) send_ctl(frdl_pkg::MODE_DATA);

    while (counted_items < TARGET_ITEMS) begin
      if ($urandom_range(0, 5) == 0) reconfigure();
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 4))
          send_item(2'($urandom), rnd64(), 24'($urandom), $urandom, $urandom, 1'b0);
      end else begin
        lookup_file();
      end
    end

    // a whole directory with no match
    reconfigure();
    send_ctl(frdl_pkg::MODE_START);
    repeat (frdl_pkg::DIR_ENTRIES + 1) begin
      miss_entry(nm, ext);
      send_item(frdl_pkg::MODE_ENTRY, nm, ext, $urandom, $urandom, 1'b1);
    end

    wait_idle();
    $display("items sent: %0d starts, %0d entries, %0d data requests, %0d unused mode",
             n_start, n_entry, n_data, n_other);
    $display("%0d results checked, %0d register writes, %0d mismatches",
             checked, n_cfg, fail_count);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
